### src/send_completion_retire_tracker_macros.svh
// assertion helpers used by the tracker top module
`ifndef SEND_COMPLETION_RETIRE_TRACKER_MACROS_SVH
`define SEND_COMPLETION_RETIRE_TRACKER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SCRT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tracker check failed");

// next-cycle implication, checked outside reset
`define SCRT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tracker check failed");

`endif

### src/scrt_pkg.sv
package scrt_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int ID_W   = 64;
   localparam int SEQ_W  = 32;
   localparam int CONN_W = 16;

   localparam logic ACTION_SEND     = 1'b0;
   localparam logic ACTION_COMPLETE = 1'b1;

   typedef enum logic [1:0] {
      KIND_ACCEPT  = 2'd0,
      KIND_FULL    = 2'd1,
      KIND_RETIRED = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic [ID_W-1:0]   work_id;
      logic [SEQ_W-1:0]  seq;
      logic              last;
   } result_type;

endpackage

### src/send_completion_retire_tracker.sv
// send: busy stays low, the accept or full result is strobed in the cycle after the start
// completion on an empty queue: one marker result in the cycle after, busy stays low
// completion retiring n >= 1 entries: busy while the walk runs, one result per cycle,
// since the queue walk reads one memory entry per cycle; retiring none gives a marker result
// results are strobed for one cycle and cannot be held off by the receiver
// synchronous reset empties the queue and clears both sequence marks and conn_id
`include "send_completion_retire_tracker_macros.svh"

module send_completion_retire_tracker #(
   parameter int DEPTH = scrt_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // request transaction
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [scrt_pkg::ID_W-1:0]     req_work_id,
   input  logic [scrt_pkg::SEQ_W-1:0]    req_seq_num,
   // response transaction
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_kind,
   output logic [scrt_pkg::ID_W-1:0]     rsp_work_id_res,
   output logic [scrt_pkg::CONN_W-1:0]   rsp_conn_out,
   output logic [scrt_pkg::SEQ_W-1:0]    rsp_retired_seq,
   output logic                          rsp_last,
   // configuration write transaction
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [scrt_pkg::CONN_W-1:0]   csr_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic                         accept;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic                         rd_en;
   logic [AW-1:0]                rd_addr;
   logic [scrt_pkg::ID_W-1:0]    rd_id;
   logic [scrt_pkg::SEQ_W-1:0]   rd_seq;
   scrt_pkg::result_type         result;

   logic [scrt_pkg::CONN_W-1:0]  conn_ff, conn_in;
   logic                         strobe_ff;
   logic [1:0]                   kind_ff;
   logic [scrt_pkg::ID_W-1:0]    work_id_ff;
   logic [scrt_pkg::SEQ_W-1:0]   seq_ff;
   logic [scrt_pkg::CONN_W-1:0]  conn_out_ff;
   logic                         last_ff;

   // a new request transaction is taken only when the walker is idle
   assign accept = start && !busy;

   // queue storage: work id and sequence number per entry
   scrt_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_id   (req_work_id),
      .wr_seq  (req_seq_num),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_id   (rd_id),
      .rd_seq  (rd_seq)
   );

   // pointers, sequence marks and the retire walk
   scrt_walker #(
      .DEPTH (DEPTH)
   ) u_walker (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .action  (req_action),
      .seq_num (req_seq_num),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_id   (rd_id),
      .rd_seq  (rd_seq),
      .result  (result),
      .busy    (busy)
   );

   // connection id register, always writable
   assign csr_ready = 1'b1;

   always_comb begin
      conn_in = conn_ff;
      if (csr_valid && csr_ready) begin
         conn_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conn_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         conn_ff   <= conn_in;
         strobe_ff <= result.valid;
      end
   end

   // response register, conn id stamped as the result leaves
   always_ff @(posedge clock) begin
      kind_ff     <= 2'(result.kind);
      work_id_ff  <= result.work_id;
      seq_ff      <= result.seq;
      conn_out_ff <= conn_ff;
      last_ff     <= result.last;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_work_id_res = work_id_ff;
   assign rsp_conn_out    = conn_out_ff;
   assign rsp_retired_seq = seq_ff;
   assign rsp_last        = last_ff;

   // a retire burst never leaves a gap before its final result
   `SCRT_ASSERT_NEXT(a_burst_no_gap, rsp_strobe && !rsp_last, rsp_strobe)
   // only retired results may be followed by more results of the same item
   `SCRT_ASSERT_NOW(a_single_is_last,
      rsp_strobe && (rsp_kind != 2'(scrt_pkg::KIND_RETIRED)), rsp_last)
   // every accepted item either answers at once or starts the walk
   `SCRT_ASSERT_NEXT(a_accept_progress, start && !busy, rsp_strobe || busy)

endmodule

### src/scrt_mem.sv
module scrt_mem #(
   parameter int DEPTH = scrt_pkg::DEPTH_DEFAULT,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [scrt_pkg::ID_W-1:0]   wr_id,
   input  logic [scrt_pkg::SEQ_W-1:0]  wr_seq,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [scrt_pkg::ID_W-1:0]   rd_id,
   output logic [scrt_pkg::SEQ_W-1:0]  rd_seq
);

   // one entry holds work id and sequence number side by side
   logic [scrt_pkg::ID_W+scrt_pkg::SEQ_W-1:0] mem [DEPTH];
   logic [scrt_pkg::ID_W+scrt_pkg::SEQ_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_id, wr_seq};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_id  = rd_data_ff[scrt_pkg::ID_W+scrt_pkg::SEQ_W-1:scrt_pkg::SEQ_W];
   assign rd_seq = rd_data_ff[scrt_pkg::SEQ_W-1:0];

endmodule

### src/scrt_walker.sv
module scrt_walker #(
   parameter int DEPTH = scrt_pkg::DEPTH_DEFAULT,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic                        action,
   input  logic [scrt_pkg::SEQ_W-1:0]  seq_num,
   output logic                        wr_en,
   output logic [AW-1:0]               wr_addr,
   output logic                        rd_en,
   output logic [AW-1:0]               rd_addr,
   input  logic [scrt_pkg::ID_W-1:0]   rd_id,
   input  logic [scrt_pkg::SEQ_W-1:0]  rd_seq,
   output scrt_pkg::result_type        result,
   output logic                        busy
);

   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WALK  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type                  state_ff, state_in;
   logic [AW-1:0]              head_ff, head_in;
   logic [AW-1:0]              tail_ff, tail_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [scrt_pkg::SEQ_W-1:0] last_ret_ff, last_ret_in;
   logic [scrt_pkg::SEQ_W-1:0] completed_ff, completed_in;
   logic [scrt_pkg::ID_W-1:0]  held_id_ff, held_id_in;
   logic [scrt_pkg::SEQ_W-1:0] held_seq_ff, held_seq_in;
   logic                       held_vld_ff, held_vld_in;
   logic                       in_window;

   function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
      logic [AW-1:0] n;
      n = p + AW'(1);
      if (p == AW'(DEPTH - 1)) begin
         n = '0;
      end
      return n;
   endfunction

   // circular window (last retired, completed]
   always_comb begin
      in_window = 1'b0;
      if (last_ret_ff < completed_ff) begin
         in_window = (rd_seq > last_ret_ff) && (rd_seq <= completed_ff);
      end else if (last_ret_ff > completed_ff) begin
         in_window = (rd_seq <= completed_ff) || (rd_seq > last_ret_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      last_ret_in  = last_ret_ff;
      completed_in = completed_ff;
      held_id_in   = held_id_ff;
      held_seq_in  = held_seq_ff;
      held_vld_in  = held_vld_ff;
      wr_en        = 1'b0;
      wr_addr      = tail_ff;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      result       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (action == scrt_pkg::ACTION_SEND) begin
                  result.valid = 1'b1;
                  result.last  = 1'b1;
                  if (count_ff == CW'(DEPTH)) begin
                     result.kind = scrt_pkg::KIND_FULL;
                  end else begin
                     result.kind = scrt_pkg::KIND_ACCEPT;
                     wr_en       = 1'b1;
                     tail_in     = next_slot(tail_ff);
                     count_in    = count_ff + CW'(1);
                  end
               end else if (count_ff == '0) begin
                  result.valid = 1'b1;
                  result.kind  = scrt_pkg::KIND_NONE;
                  result.last  = 1'b1;
               end else begin
                  completed_in = seq_num;
                  rd_en        = 1'b1;
                  held_vld_in  = 1'b0;
                  state_in     = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (in_window) begin
               // the previous retire is known not to be the final one
               if (held_vld_ff) begin
                  result.valid   = 1'b1;
                  result.kind    = scrt_pkg::KIND_RETIRED;
                  result.work_id = held_id_ff;
                  result.seq     = held_seq_ff;
               end
               held_id_in  = rd_id;
               held_seq_in = rd_seq;
               held_vld_in = 1'b1;
               last_ret_in = rd_seq;
               head_in     = next_slot(head_ff);
               count_in    = count_ff - CW'(1);
               if (count_ff == CW'(1)) begin
                  state_in = ST_DRAIN;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = next_slot(head_ff);
               end
            end else begin
               result.valid = 1'b1;
               result.last  = 1'b1;
               if (held_vld_ff) begin
                  result.kind    = scrt_pkg::KIND_RETIRED;
                  result.work_id = held_id_ff;
                  result.seq     = held_seq_ff;
               end else begin
                  result.kind = scrt_pkg::KIND_NONE;
               end
               state_in = ST_IDLE;
            end
         end
         ST_DRAIN: begin
            result.valid   = 1'b1;
            result.kind    = scrt_pkg::KIND_RETIRED;
            result.work_id = held_id_ff;
            result.seq     = held_seq_ff;
            result.last    = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         last_ret_ff  <= '0;
         completed_ff <= '0;
         held_vld_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         last_ret_ff  <= last_ret_in;
         completed_ff <= completed_in;
         held_vld_ff  <= held_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      held_id_ff  <= held_id_in;
      held_seq_ff <= held_seq_in;
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### tb/sv/scrt_retire_checker.sv
module scrt_retire_checker #(
   parameter int DEPTH = scrt_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic                          req_action,
   input  logic [scrt_pkg::ID_W-1:0]     req_work_id,
   input  logic [scrt_pkg::SEQ_W-1:0]    req_seq_num,
   input  logic                          rsp_strobe,
   input  logic [1:0]                    rsp_kind,
   input  logic [scrt_pkg::ID_W-1:0]     rsp_work_id_res,
   input  logic [scrt_pkg::CONN_W-1:0]   rsp_conn_out,
   input  logic [scrt_pkg::SEQ_W-1:0]    rsp_retired_seq,
   input  logic                          rsp_last,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [scrt_pkg::CONN_W-1:0]   csr_data,
   output int unsigned                   mismatch_count,
   output int unsigned                   open_count,
   output int unsigned                   result_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      scrt_pkg::kind_type            kind;
      logic [scrt_pkg::ID_W-1:0]     work_id;
      logic [scrt_pkg::CONN_W-1:0]   conn;
      logic [scrt_pkg::SEQ_W-1:0]    seq;
      logic                          last;
   } outcome_type;

   // shadow copy of the pending queue and sequence marks
   logic [scrt_pkg::ID_W-1:0]     shadow_ids  [DEPTH];
   logic [scrt_pkg::SEQ_W-1:0]    shadow_seqs [DEPTH];
   int                            sh_head;
   int                            sh_tail;
   int                            sh_count;
   logic [scrt_pkg::SEQ_W-1:0]    sh_last_retired;
   logic [scrt_pkg::SEQ_W-1:0]    sh_completed;
   logic [scrt_pkg::CONN_W-1:0]   sh_conn;

   outcome_type         due_results [$];
   int unsigned         miss_total = 0;
   int unsigned         seen_total = 0;

   // circular window (last retired, completed]
   function automatic bit seq_in_window(input logic [scrt_pkg::SEQ_W-1:0] s);
      if (sh_last_retired < sh_completed)
         return (s > sh_last_retired) && (s <= sh_completed);
      if (sh_last_retired > sh_completed)
         return (s <= sh_completed) || (s > sh_last_retired);
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch, %s", $time, what);
      miss_total++;
   endtask

   // applies one request to the shadow queue and lists the results it causes
   task automatic track_request(input logic act, input logic [scrt_pkg::ID_W-1:0] wid,
                                input logic [scrt_pkg::SEQ_W-1:0] seq);
      outcome_type res;
      res.kind    = scrt_pkg::KIND_ACCEPT;
      res.work_id = '0;
      res.conn    = sh_conn;
      res.seq     = '0;
      res.last    = 1'b1;
      if (act == scrt_pkg::ACTION_SEND) begin
         if (sh_count >= DEPTH) begin
            res.kind = scrt_pkg::KIND_FULL;
         end else begin
            shadow_ids[sh_tail]  = wid;
            shadow_seqs[sh_tail] = seq;
            sh_tail = (sh_tail + 1 == DEPTH) ? 0 : sh_tail + 1;
            sh_count++;
         end
         due_results.push_back(res);
      end else if (sh_count == 0) begin
         // empty queue leaves the completed mark alone
         res.kind = scrt_pkg::KIND_NONE;
         due_results.push_back(res);
      end else begin
         sh_completed = seq;
         if (!seq_in_window(shadow_seqs[sh_head])) begin
            res.kind = scrt_pkg::KIND_NONE;
            due_results.push_back(res);
         end
         while (sh_count > 0 && seq_in_window(shadow_seqs[sh_head])) begin
            res.kind        = scrt_pkg::KIND_RETIRED;
            res.work_id     = shadow_ids[sh_head];
            res.seq         = shadow_seqs[sh_head];
            sh_last_retired = res.seq;
            sh_head         = (sh_head + 1 == DEPTH) ? 0 : sh_head + 1;
            sh_count--;
            res.last = !(sh_count > 0 && seq_in_window(shadow_seqs[sh_head]));
            due_results.push_back(res);
         end
      end
   endtask

   always @(posedge clock) begin : watch
      outcome_type want;
      if (reset) begin
         sh_head         = 0;
         sh_tail         = 0;
         sh_count        = 0;
         sh_last_retired = '0;
         sh_completed    = '0;
         sh_conn         = '0;
         due_results.delete();
      end else begin
         if (rsp_strobe === 1'b1) begin
            seen_total++;
            if (due_results.size() == 0) begin
               report_mismatch("result strobed with nothing outstanding");
            end else begin
               want = due_results.pop_front();
               if (rsp_kind !== want.kind)
                  report_mismatch($sformatf("kind %0d, want %0d", rsp_kind, want.kind));
               if (rsp_work_id_res !== want.work_id)
                  report_mismatch($sformatf("work id %h, want %h", rsp_work_id_res,
                                            want.work_id));
               if (rsp_conn_out !== want.conn)
                  report_mismatch($sformatf("conn %h, want %h", rsp_conn_out, want.conn));
               if (rsp_retired_seq !== want.seq)
                  report_mismatch($sformatf("retired seq %h, want %h", rsp_retired_seq,
                                            want.seq));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %b, want %b", rsp_last, want.last));
            end
         end else if (rsp_strobe !== 1'b0) begin
            report_mismatch("result strobe unknown");
         end
         if (csr_valid === 1'b1 && csr_ready === 1'b1)
            sh_conn = csr_data;
         if (start === 1'b1 && busy === 1'b0)
            track_request(req_action, req_work_id, req_seq_num);
      end
      mismatch_count <= miss_total;
      open_count     <= due_results.size();
      result_count   <= seen_total;
   end

endmodule

### tb/sv/send_completion_retire_tracker_test.sv
module send_completion_retire_tracker_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QDEPTH       = scrt_pkg::DEPTH_DEFAULT;
   // worst item is a full walk plus a long gap, a few hundred items at most
   localparam int LIMIT_CYCLES = 200000;

   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;
   logic                           start       = 1'b0;
   logic                           busy;
   logic                           req_action  = scrt_pkg::ACTION_SEND;
   logic [scrt_pkg::ID_W-1:0]      req_work_id = '0;
   logic [scrt_pkg::SEQ_W-1:0]     req_seq_num = '0;
   logic                           rsp_strobe;
   logic [1:0]                     rsp_kind;
   logic [scrt_pkg::ID_W-1:0]      rsp_work_id_res;
   logic [scrt_pkg::CONN_W-1:0]    rsp_conn_out;
   logic [scrt_pkg::SEQ_W-1:0]     rsp_retired_seq;
   logic                           rsp_last;
   logic                           csr_valid   = 1'b0;
   logic                           csr_ready;
   logic [scrt_pkg::CONN_W-1:0]    csr_data    = '0;

   int unsigned          bad_count;
   int unsigned          open_results;
   int unsigned          result_total;

   int unsigned          item_total  = 0;
   int unsigned          conn_writes = 0;
   int unsigned          cycle_count = 0;
   bit                   quiet       = 1'b0;   // no idle bursts while set
   logic [scrt_pkg::SEQ_W-1:0]     next_seq;   // sequence number of the next send
   logic [scrt_pkg::SEQ_W-1:0]     ack_seq;    // highest completion handed out so far

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   send_completion_retire_tracker #(.DEPTH(QDEPTH)) u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_work_id     (req_work_id),
      .req_seq_num     (req_seq_num),
      .rsp_strobe      (rsp_strobe),
      .rsp_kind        (rsp_kind),
      .rsp_work_id_res (rsp_work_id_res),
      .rsp_conn_out    (rsp_conn_out),
      .rsp_retired_seq (rsp_retired_seq),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   // predicts and compares every result transaction
   scrt_retire_checker #(.DEPTH(QDEPTH)) u_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_work_id     (req_work_id),
      .req_seq_num     (req_seq_num),
      .rsp_strobe      (rsp_strobe),
      .rsp_kind        (rsp_kind),
      .rsp_work_id_res (rsp_work_id_res),
      .rsp_conn_out    (rsp_conn_out),
      .rsp_retired_seq (rsp_retired_seq),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .mismatch_count  (bad_count),
      .open_count      (open_results),
      .result_count    (result_total)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results still due", cycle_count,
                  open_results);
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic logic [scrt_pkg::ID_W-1:0] rand_id();
      return {$urandom, $urandom};
   endfunction

   // one request transaction; start stays high after acceptance so that
   // back-to-back requests need no second assignment in the same step
   task automatic push_item(input logic act, input logic [scrt_pkg::ID_W-1:0] wid,
                            input logic [scrt_pkg::SEQ_W-1:0] seq);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      start       <= 1'b1;
      req_action  <= act;
      req_work_id <= wid;
      req_seq_num <= seq;
      // busy is sampled as it was at the edge
      do @(posedge clock); while (busy !== 1'b0);
      item_total++;
   endtask

   // block idle: every result seen and no walk in progress
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (open_results != 0 || busy !== 1'b0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_conn_id(input logic [scrt_pkg::CONN_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      conn_writes++;
   endtask

   // in-order sends with random work ids; completions walk forward, so most
   // transactions retire something instead of stalling on the head entry
   task automatic random_phase(input int count, input int send_pct, input bit calm_tail);
      int            r;
      logic [31:0]   span;
      for (int k = 0; k < count; k++) begin
         if (calm_tail && k >= count / 2)
            quiet = 1'b1;
         else if ($urandom_range(0, 19) == 0)
            quiet = !quiet;
         r = $urandom_range(0, 99);
         if (r < send_pct - 6) begin
            push_item(scrt_pkg::ACTION_SEND, rand_id(), next_seq);
            next_seq++;
         end else if (r < send_pct) begin
            // skip ahead in sequence space
            next_seq += $urandom_range(2, 5000);
            push_item(scrt_pkg::ACTION_SEND, rand_id(), next_seq);
            next_seq++;
         end else if (r < 94) begin
            // well-formed completion somewhere up to the newest send
            span = (next_seq - 1 - ack_seq) >> $urandom_range(0, 3);
            ack_seq += $urandom_range(0, span);
            push_item(scrt_pkg::ACTION_COMPLETE, rand_id(), ack_seq);
         end else begin
            // stray completion number
            push_item(scrt_pkg::ACTION_COMPLETE, rand_id(), $urandom);
         end
      end
   endtask

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_conn_id(16'hFFFF);

      // completion on an empty queue, marks stay put
      push_item(scrt_pkg::ACTION_COMPLETE, '1, 32'hFFFF_FFFF);
      push_item(scrt_pkg::ACTION_SEND, '1, 32'd1);
      push_item(scrt_pkg::ACTION_SEND, '0, 32'd2);
      push_item(scrt_pkg::ACTION_SEND, 64'h8000_0000_0000_0001, 32'd3);
      // completion equal to last retired: empty window
      push_item(scrt_pkg::ACTION_COMPLETE, '0, 32'd0);
      // retires seq 1 and 2
      push_item(scrt_pkg::ACTION_COMPLETE, rand_id(), 32'd2);
      push_item(scrt_pkg::ACTION_COMPLETE, rand_id(), 32'd2);
      // lower completion wraps the window all the way round, seq 3 retires
      push_item(scrt_pkg::ACTION_COMPLETE, rand_id(), 32'd1);
      // head outside the window still moves the completed mark
      push_item(scrt_pkg::ACTION_SEND, rand_id(), 32'd10);
      push_item(scrt_pkg::ACTION_COMPLETE, rand_id(), 32'd5);
      push_item(scrt_pkg::ACTION_COMPLETE, rand_id(), 32'd10);
      // sequence wrap across zero
      push_item(scrt_pkg::ACTION_SEND, rand_id(), 32'hFFFF_FFFE);
      push_item(scrt_pkg::ACTION_SEND, rand_id(), 32'hFFFF_FFFF);
      push_item(scrt_pkg::ACTION_SEND, rand_id(), 32'h0000_0000);
      push_item(scrt_pkg::ACTION_COMPLETE, rand_id(), 32'hFFFF_FFFF);
      push_item(scrt_pkg::ACTION_COMPLETE, rand_id(), 32'h0000_0001);

      // fill to the brim, one refused send, then one completion drains all
      for (int i = 1; i <= QDEPTH + 1; i++)
         push_item(scrt_pkg::ACTION_SEND, rand_id(), 32'(i));
      push_item(scrt_pkg::ACTION_COMPLETE, rand_id(), 32'(QDEPTH));
      next_seq = 32'(QDEPTH + 1);
      ack_seq  = 32'(QDEPTH);

      settle();
      write_conn_id(16'h0000);
      random_phase(63, 65, 1'b0);

      // walk the sequence numbers across the wrap point
      settle();
      write_conn_id(16'($urandom));
      next_seq = 32'hFFFF_FFC0;
      ack_seq  = next_seq - 1;
      random_phase(63, 85, 1'b0);

      settle();
      write_conn_id(16'h5AA5);
      next_seq = $urandom;
      ack_seq  = next_seq - 1;
      random_phase(63, 50, 1'b0);

      // second half of the last part runs without idle bursts
      settle();
      write_conn_id(16'($urandom));
      random_phase(63, 70, 1'b1);

      start <= 1'b0;
      while (open_results != 0) @(posedge clock);
      // catch any stray result after a full walk
      repeat (QDEPTH + 8) @(posedge clock);

      $display("summary: %0d request transactions, %0d result transactions, %0d conn_id writes",
               item_total, result_total, conn_writes);
      $display("summary: empty and wrapped windows, full queue, 32-entry drain, random phases");
      if (bad_count == 0 && open_results == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
